// File: design/atq_pkg.sv
// Shared types and constants for the alarm time queue.
`timescale 1ns / 1ps

package atq_pkg;

    localparam int ATQ_DEPTH = 16;

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] alarm_id;
        logic [31:0] time_secs;
    } t_in_item;

    typedef struct packed {
        logic        fired;
        logic [15:0] fired_id;
        logic        dropped_full;
        logic [4:0]  pending_count;
    } t_out_item;

    typedef struct packed {
        logic [15:0] alarm_id;
        logic [31:0] time_secs;
    } t_entry;

    typedef struct packed {
        logic accept;
        logic add;
        logic scan_start;
        logic scan_step;
        logic fire;
        logic shift_step;
        logic shift_end;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic empty;
        logic walk_done;
        logic match;
        logic out_free;
    } t_status;

endpackage

// File: design/atq_ctrl.sv
// Controller state machine for the alarm time queue.
`timescale 1ns / 1ps

module atq_ctrl
    import atq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_sts,
    output t_cmd    o_cmd,
    output logic    o_in_stall
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DISP  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_SHIFT = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DISP;
                end
            end
            S_DISP: begin
                if (!i_sts.is_tick) begin
                    o_cmd.add = 1'b1;
                    n_state   = S_OUT;
                end else if (i_sts.empty) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.walk_done) begin
                    if (i_sts.match) begin
                        o_cmd.fire = 1'b1;
                        n_state    = S_SHIFT;
                    end else begin
                        n_state = S_OUT;
                    end
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_SHIFT: begin
                if (i_sts.walk_done) begin
                    o_cmd.shift_end = 1'b1;
                    n_state         = S_OUT;
                end else begin
                    o_cmd.shift_step = 1'b1;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;

endmodule

// File: design/atq_datapath.sv
// Datapath of the alarm time queue: alarm table memory, scan, removal and result register.
`timescale 1ns / 1ps

module atq_datapath
    import atq_pkg::*;
#(
    parameter int DEPTH = ATQ_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    output t_status   o_sts,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_result
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          mem [DEPTH];
    t_entry          r_rd;
    t_entry          r_best;
    t_in_item        r_item;
    t_out_item       r_out;
    logic [IW-1:0]   r_best_idx;
    logic [IW-1:0]   r_pidx;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_ptr;
    logic            r_pv;
    logic            r_out_valid;
    logic            r_fired;
    logic [15:0]     r_fired_id;
    logic            r_dropped;
    logic            full;
    logic            ptr_live;
    logic            rd_en;
    logic            wr_add;
    logic            better;
    logic [CW+4:0]   cnt_ext;

    assign full     = (r_count == CW'(DEPTH));
    assign ptr_live = (r_ptr < r_count);
    assign rd_en    = (i_cmd.scan_step || i_cmd.shift_step) && ptr_live;
    assign wr_add   = i_cmd.add && !full;
    assign better   = (r_pidx == '0) || (r_rd.time_secs < r_best.time_secs);
    assign cnt_ext  = (CW + 5)'(r_count);

    always_ff @(posedge i_clk) begin
        if (wr_add) begin
            mem[r_count[IW-1:0]] <= '{alarm_id: r_item.alarm_id, time_secs: r_item.time_secs};
        end else if (i_cmd.shift_step && r_pv) begin
            mem[r_pidx] <= r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd <= mem[r_ptr[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ptr       <= '0;
            r_pv        <= 1'b0;
            r_pidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (wr_add) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.shift_end) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_ptr <= '0;
                r_pv  <= 1'b0;
            end
            if (i_cmd.fire) begin
                r_ptr <= CW'(r_best_idx) + 1'b1;
                r_pv  <= 1'b0;
            end
            if (i_cmd.scan_step || i_cmd.shift_step) begin
                if (ptr_live) begin
                    r_ptr  <= r_ptr + 1'b1;
                    r_pv   <= 1'b1;
                    r_pidx <= i_cmd.scan_step ? IW'(r_ptr) : IW'(r_ptr - 1'b1);
                end else begin
                    r_pv <= 1'b0;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item     <= i_in_item;
            r_fired    <= 1'b0;
            r_fired_id <= '0;
            r_dropped  <= 1'b0;
        end
        if (i_cmd.add && full) begin
            r_dropped <= 1'b1;
        end
        if (i_cmd.scan_step && r_pv && better) begin
            r_best     <= r_rd;
            r_best_idx <= r_pidx;
        end
        if (i_cmd.fire) begin
            r_fired    <= 1'b1;
            r_fired_id <= r_best.alarm_id;
        end
        if (i_cmd.load_out) begin
            r_out.fired         <= r_fired;
            r_out.fired_id      <= r_fired_id;
            r_out.dropped_full  <= r_dropped;
            r_out.pending_count <= cnt_ext[4:0];
        end
    end

    assign o_sts.is_tick   = (r_item.func == FUNC_TICK);
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.walk_done = !ptr_live && !r_pv;
    assign o_sts.match     = (r_best.time_secs == r_item.time_secs);
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_out_result = r_out;

endmodule

// File: design/alarm_time_queue.sv
// Top level of the alarm time queue.
`timescale 1ns / 1ps

// The alarm time queue holds up to DEPTH alarms (identifier and due second) in insertion
// order and returns exactly one result transfer per input transfer. Items are handled one
// at a time, through a table memory with one write port and one registered read port. An
// add, like a tick on an empty table, goes from dispatch straight to the result stage. A
// tick on a held table walks every entry once to find the earliest due time, the oldest on
// ties. When it fires, the younger entries move down one place at one entry a cycle.
// While an item is in work, input is stalled; a finished result may wait in the output
// register while the next item is taken in.
module alarm_time_queue
    import atq_pkg::*;
#(
    parameter int DEPTH = ATQ_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_result
);

    t_cmd    cmd;
    t_status sts;

    atq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    atq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_in_item    (i_in_item),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_result (o_out_result)
    );

endmodule

// File: design/atq_checker.sv
// Port-level assertions for the alarm time queue and their binding.
`timescale 1ns / 1ps

module atq_checker
    import atq_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_result
);

    // A result held back by the receiver stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_result))
        else $error("result changed while stalled");

    // One item is in work at a time, so an input transfer closes the input side.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken twice in a row");

    // A fired alarm comes only from a tick, a dropped one only from an add.
    a_fire_xor_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_result.fired && o_out_result.dropped_full))
        else $error("fired and dropped_full together");

    // Without a firing the reported identifier is zero.
    a_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_result.fired |-> o_out_result.fired_id == 16'd0)
        else $error("fired_id set without a firing");

endmodule

bind alarm_time_queue atq_checker u_atq_checker (.*);

// File: verif/alarm_time_queue_tb.sv
// Self-checking testbench for the alarm time queue with directed and random transfers.
`timescale 1ns / 1ps

module alarm_time_queue_tb;
    import atq_pkg::*;

    localparam int STALL_PCT      = 18;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 2 * ATQ_DEPTH + 8;

    logic      i_clk        = 1'b0;
    logic      i_rst_n      = 1'b0;
    logic      i_in_valid   = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item    = '0;
    logic      o_out_valid;
    logic      i_out_stall  = 1'b0;
    t_out_item o_out_result;

    t_entry    alarm_table[$];
    t_out_item queued_reports[$];
    int        mismatch_count = 0;
    int        silent_cycles  = 0;
    bit        steady_flow    = 1'b0;

    alarm_time_queue i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_result (o_out_result)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_in_item make_item(input logic func, input logic [15:0] id,
                                           input logic [31:0] secs);
        t_in_item item;
        item.func      = func;
        item.alarm_id  = id;
        item.time_secs = secs;
        return item;
    endfunction

    function automatic t_out_item alarm_table_step(input t_in_item item);
        t_out_item report;
        t_entry    entry;
        int        best;
        report = '0;
        if (item.func == FUNC_ADD) begin
            if (alarm_table.size() >= ATQ_DEPTH) begin
                report.dropped_full = 1'b1;
            end else begin
                entry.alarm_id  = item.alarm_id;
                entry.time_secs = item.time_secs;
                alarm_table.insert(alarm_table.size(), entry);
            end
        end else if (alarm_table.size() > 0) begin
            best = 0;
            for (int k = 1; k < alarm_table.size(); k++) begin
                if (alarm_table[k].time_secs < alarm_table[best].time_secs) begin
                    best = k;
                end
            end
            if (alarm_table[best].time_secs == item.time_secs) begin
                report.fired    = 1'b1;
                report.fired_id = alarm_table[best].alarm_id;
                alarm_table.delete(best);
            end
        end
        report.pending_count = 5'(alarm_table.size());
        return report;
    endfunction

    task automatic send_alarm_item(input t_in_item item);
        while (!steady_flow && $urandom_range(0, 99) < STALL_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        do @(negedge i_clk); while (o_in_stall);
        queued_reports.insert(queued_reports.size(), alarm_table_step(item));
        @(posedge i_clk);
    endtask

    task automatic test_empty_table();
        send_alarm_item(make_item(FUNC_TICK, 16'h0000, 32'h0000_0000));
        send_alarm_item(make_item(FUNC_TICK, 16'hFFFF, 32'hFFFF_FFFF));
    endtask

    task automatic test_fill_and_overflow();
        logic [15:0] id;
        logic [31:0] due;
        for (int k = 0; k < ATQ_DEPTH; k++) begin
            case (k)
                0: begin
                    id  = 16'h0000;
                    due = 32'hFFFF_FFFF;
                end
                1: begin
                    id  = 16'hFFFF;
                    due = 32'd100;
                end
                5: begin
                    id  = 16'hA5A5;
                    due = 32'd0;
                end
                3, 9: begin
                    id  = 16'h5A00 + 16'(k);
                    due = 32'd7;
                end
                default: begin
                    id  = 16'h1000 + 16'(k);
                    due = 32'd50 + 32'(k);
                end
            endcase
            send_alarm_item(make_item(FUNC_ADD, id, due));
        end
        send_alarm_item(make_item(FUNC_ADD, 16'h7E7E, 32'd1));
    endtask

    // The two alarms due at second 7 must fire oldest first, one per tick.
    task automatic test_fire_order();
        send_alarm_item(make_item(FUNC_TICK, 16'h0000, 32'd0));
        send_alarm_item(make_item(FUNC_TICK, 16'h0000, 32'd8));
        send_alarm_item(make_item(FUNC_TICK, 16'h0000, 32'd6));
        send_alarm_item(make_item(FUNC_TICK, 16'h0000, 32'd7));
        send_alarm_item(make_item(FUNC_TICK, 16'h0000, 32'd7));
    endtask

    // Phases alternate between filling and draining so that both the full and the empty
    // table are reached; most ticks carry the earliest due second and so fire.
    task automatic test_random_traffic(input int item_total);
        t_in_item    item;
        int          add_pct;
        int          pick;
        logic [31:0] earliest;
        logic [31:0] time_base;
        time_base = $urandom();
        for (int n = 0; n < item_total; n++) begin
            steady_flow = (n >= item_total / 3) && (n < item_total / 3 + 300);
            if (n % 64 == 0) begin
                time_base = $urandom();
            end
            if (alarm_table.size() == 0) begin
                add_pct = 80;
            end else if ((n / 120) % 2 == 0) begin
                add_pct = 65;
            end else begin
                add_pct = 30;
            end
            item.alarm_id = 16'($urandom());
            if ($urandom_range(0, 99) < add_pct) begin
                item.func = FUNC_ADD;
                if ($urandom_range(0, 99) < 70) begin
                    item.time_secs = time_base + 32'($urandom_range(0, 15));
                end else begin
                    item.time_secs = $urandom();
                end
            end else begin
                item.func = FUNC_TICK;
                earliest  = $urandom();
                foreach (alarm_table[k]) begin
                    if (k == 0 || alarm_table[k].time_secs < earliest) begin
                        earliest = alarm_table[k].time_secs;
                    end
                end
                pick = $urandom_range(0, 99);
                if (alarm_table.size() != 0 && pick < 60) begin
                    item.time_secs = earliest;
                end else if (alarm_table.size() != 0 && pick < 80) begin
                    item.time_secs =
                        alarm_table[$urandom_range(0, alarm_table.size() - 1)].time_secs;
                end else if (pick < 92) begin
                    item.time_secs = earliest + 32'($urandom_range(0, 2)) - 32'd1;
                end else begin
                    item.time_secs = $urandom();
                end
            end
            send_alarm_item(item);
        end
        steady_flow = 1'b0;
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= !steady_flow && ($urandom_range(0, 99) < STALL_PCT);
    end

    always @(negedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (queued_reports.size() == 0) begin
                $error("unexpected result transfer: %h", o_out_result);
                mismatch_count++;
            end else begin
                want = queued_reports.pop_front();
                if (o_out_result.fired !== want.fired) begin
                    $error("fired: expected %0d, actual %0d", want.fired, o_out_result.fired);
                    mismatch_count++;
                end
                if (o_out_result.fired_id !== want.fired_id) begin
                    $error("fired_id: expected %h, actual %h",
                           want.fired_id, o_out_result.fired_id);
                    mismatch_count++;
                end
                if (o_out_result.dropped_full !== want.dropped_full) begin
                    $error("dropped_full: expected %0d, actual %0d",
                           want.dropped_full, o_out_result.dropped_full);
                    mismatch_count++;
                end
                if (o_out_result.pending_count !== want.pending_count) begin
                    $error("pending_count: expected %0d, actual %0d",
                           want.pending_count, o_out_result.pending_count);
                    mismatch_count++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            silent_cycles <= 0;
        end else begin
            silent_cycles <= silent_cycles + 1;
        end
        if (silent_cycles >= WATCHDOG_LIMIT) begin
            $display("alarm_time_queue regression: fail");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_fill_and_overflow();
        test_fire_order();
        test_random_traffic(1700);
        i_in_valid <= 1'b0;
        while (queued_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && queued_reports.size() == 0) begin
            $display("alarm_time_queue regression: pass");
        end else begin
            $display("alarm_time_queue regression: fail");
        end
        $finish;
    end

endmodule
